[src/ssw_pkg.sv]
// shared types, constants and the exp table function for the splat weight block
`default_nettype none

package ssw_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTED_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT    = 2'd3;

   localparam logic [3:0]  SCALE_RESET  = 4'd2;
   localparam logic        MODE_RESET   = 1'b1;
   localparam logic [14:0] WIDTH_RESET  = 15'd8192;
   localparam logic [14:0] HEIGHT_RESET = 15'd6144;
   localparam logic [14:0] GRID_LIMIT   = 15'd16384;

   localparam logic [8:0]  CONF_ONE     = 9'd256;
   localparam logic [16:0] WEIGHT_FLOOR = 17'd655;
   localparam logic [63:0] ONE_Q30      = 64'd1 << 30;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef struct packed {
      logic [11:0]        pixel_x;
      logic [11:0]        pixel_y;
      color_type          color;
      logic signed [13:0] motion_dx;
      logic signed [13:0] motion_dy;
      logic [8:0]         confidence;
   } req_type;

   typedef struct packed {
      logic [3:0]  scale;
      logic [14:0] wlim;
      logic [14:0] hlim;
   } cfg_type;

   // corner k: column select k[0], row select k[1]
   typedef struct packed {
      logic [3:0]       inb;
      logic [1:0][13:0] ox;
      logic [1:0][13:0] oy;
      logic [1:0][8:0]  ddx;
      logic [1:0][8:0]  ddy;
   } geo_type;

   typedef struct packed {
      logic [3:0]       inb;
      logic [1:0][13:0] ox;
      logic [1:0][13:0] oy;
      color_type        color;
      logic [8:0]       conf;
   } carry_type;

   typedef struct packed {
      logic [3:0]       keep;
      logic [3:0][16:0] weight;
      logic [1:0][13:0] ox;
      logic [1:0][13:0] oy;
      color_type        color;
   } splat_type;

   // exp(-x) in Q1.16 from x in Q.30: taylor series of exp(-x/8), squared three times
   function automatic logic [16:0] exp_q16(input logic [63:0] x);
      logic [63:0]        y;
      logic [63:0]        term;
      logic [63:0]        s;
      logic signed [63:0] sum;
      y    = x >> 3;
      term = ONE_Q30;
      sum  = signed'(ONE_Q30);
      term = ((term * y) >> 30) / 64'd1;  sum = sum - signed'(term);
      term = ((term * y) >> 30) / 64'd2;  sum = sum + signed'(term);
      term = ((term * y) >> 30) / 64'd3;  sum = sum - signed'(term);
      term = ((term * y) >> 30) / 64'd4;  sum = sum + signed'(term);
      term = ((term * y) >> 30) / 64'd5;  sum = sum - signed'(term);
      term = ((term * y) >> 30) / 64'd6;  sum = sum + signed'(term);
      term = ((term * y) >> 30) / 64'd7;  sum = sum - signed'(term);
      term = ((term * y) >> 30) / 64'd8;  sum = sum + signed'(term);
      term = ((term * y) >> 30) / 64'd9;  sum = sum - signed'(term);
      term = ((term * y) >> 30) / 64'd10; sum = sum + signed'(term);
      s = (sum > 64'sd0) ? unsigned'(sum) : 64'd0;
      s = (s * s) >> 30;
      s = (s * s) >> 30;
      s = (s * s) >> 30;
      return 17'((s * 64'd65536 + (64'd1 << 29)) >> 30);
   endfunction

endpackage

`default_nettype wire

[src/ssw_if.sv]
// valid/ready channel interfaces for pixel requests and splat responses
`default_nettype none

interface ssw_req_if;
   logic               valid;
   logic               ready;
   logic [11:0]        pixel_x;
   logic [11:0]        pixel_y;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   logic signed [13:0] motion_dx;
   logic signed [13:0] motion_dy;
   logic [8:0]         confidence;

   modport source (output valid, pixel_x, pixel_y, red, green, blue, motion_dx, motion_dy,
                   confidence, input ready);
   modport sink (input valid, pixel_x, pixel_y, red, green, blue, motion_dx, motion_dy,
                 confidence, output ready);
endinterface

interface ssw_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] out_x;
   logic [13:0] out_y;
   logic [16:0] splat_weight;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic        last_of_pixel;

   modport source (output valid, out_x, out_y, splat_weight, out_red, out_green, out_blue,
                   last_of_pixel, input ready);
   modport sink (input valid, out_x, out_y, splat_weight, out_red, out_green, out_blue,
                 last_of_pixel, output ready);
endinterface

`default_nettype wire

[src/ssw_position.sv]
// two stages: scaled grid position, then corner coordinates, distances and bounds
`default_nettype none

module ssw_position (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire ssw_pkg::req_type in_item,
   input  wire ssw_pkg::cfg_type cfg,
   output logic                 out_valid,
   output ssw_pkg::geo_type     out_geo,
   output ssw_pkg::color_type   out_color,
   output logic [8:0]           out_conf
);

   logic                      v1_ff;
   logic signed [26:0]        posx_ff, posx_in;
   logic signed [26:0]        posy_ff, posy_in;
   ssw_pkg::color_type        color1_ff;
   logic [8:0]                conf1_ff, conf1_in;
   logic signed [21:0]        diffx, diffy;
   logic signed [4:0]         scale_s;

   logic                      v2_ff;
   ssw_pkg::geo_type          geo_ff, geo_in;
   ssw_pkg::color_type        color2_ff;
   logic [8:0]                conf2_ff;
   logic signed [18:0]        x0, y0;
   logic [1:0][18:0]          ox, oy;
   logic [1:0]                inbx, inby;

   always_comb begin
      diffx   = signed'({2'b00, in_item.pixel_x, 8'h00}) - 22'(in_item.motion_dx);
      diffy   = signed'({2'b00, in_item.pixel_y, 8'h00}) - 22'(in_item.motion_dy);
      scale_s = signed'({1'b0, cfg.scale});
      posx_in = 27'(diffx) * 27'(scale_s);
      posy_in = 27'(diffy) * 27'(scale_s);
      conf1_in = (in_item.confidence > ssw_pkg::CONF_ONE) ? ssw_pkg::CONF_ONE
                                                          : in_item.confidence;
   end

   // arithmetic shift of a Q.8 value is floor toward minus infinity
   always_comb begin
      x0 = posx_ff[26:8];
      y0 = posy_ff[26:8];
      ox[0] = x0;
      ox[1] = x0 + 19'sd1;
      oy[0] = y0;
      oy[1] = y0 + 19'sd1;
      for (int n = 0; n < 2; n++) begin
         inbx[n] = !ox[n][18] && (ox[n] < signed'({4'b0000, cfg.wlim}));
         inby[n] = !oy[n][18] && (oy[n] < signed'({4'b0000, cfg.hlim}));
         geo_in.ox[n] = ox[n][13:0];
         geo_in.oy[n] = oy[n][13:0];
      end
      for (int k = 0; k < 4; k++) begin
         geo_in.inb[k] = inbx[k % 2] && inby[k / 2];
      end
      geo_in.ddx[0] = {1'b0, posx_ff[7:0]};
      geo_in.ddx[1] = 9'd256 - {1'b0, posx_ff[7:0]};
      geo_in.ddy[0] = {1'b0, posy_ff[7:0]};
      geo_in.ddy[1] = 9'd256 - {1'b0, posy_ff[7:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         posx_ff   <= posx_in;
         posy_ff   <= posy_in;
         color1_ff <= in_item.color;
         conf1_ff  <= conf1_in;
         geo_ff    <= geo_in;
         color2_ff <= color1_ff;
         conf2_ff  <= conf1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_geo   = geo_ff;
   assign out_color = color2_ff;
   assign out_conf  = conf2_ff;

endmodule

`default_nettype wire

[src/ssw_weight.sv]
// four-lane weight pipeline: squared distance, table index, exp lookup, final weight
`default_nettype none

module ssw_weight #(
   parameter int ENTRIES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              weighted_mode,
   input  wire logic              in_valid,
   input  wire ssw_pkg::geo_type   in_geo,
   input  wire ssw_pkg::color_type in_color,
   input  wire logic [8:0]        in_conf,
   output logic                   out_valid,
   output ssw_pkg::splat_type     out_splat
);

   localparam int SPAN   = ENTRIES - 1;
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int PROD_W = 18 + IDX_W + 1;

   logic [16:0] rom [ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_rom
      localparam logic [63:0] XV = (64'(100 * i) << 30) / (64'd49 * 64'(SPAN));
      assign rom[i] = ssw_pkg::exp_q16(XV);
   end

   logic                         v3_ff, v4_ff, v5_ff, v6_ff;
   ssw_pkg::carry_type           c3_ff, c3_in, c4_ff, c5_ff;
   logic [3:0][17:0]             d2_ff, d2_in;
   logic [3:0][16:0]             bil3_ff, bil3_in, bil4_ff, bil5_ff;
   logic [3:0][IDX_W-1:0]        idx_ff, idx_in;
   logic [3:0][16:0]             entry_ff;
   ssw_pkg::splat_type           splat_ff, splat_in;
   logic [3:0][8:0]              ddx, ddy;
   logic [3:0][PROD_W-1:0]       iprod;
   logic [3:0][25:0]             gprod;
   logic [3:0][16:0]             wsel;

   // stage 3: squared distance and bilinear weight per corner
   always_comb begin
      c3_in.inb   = in_geo.inb;
      c3_in.ox    = in_geo.ox;
      c3_in.oy    = in_geo.oy;
      c3_in.color = in_color;
      c3_in.conf  = in_conf;
      for (int k = 0; k < 4; k++) begin
         ddx[k]     = in_geo.ddx[k % 2];
         ddy[k]     = in_geo.ddy[k / 2];
         d2_in[k]   = 18'(ddx[k]) * 18'(ddx[k]) + 18'(ddy[k]) * 18'(ddy[k]);
         bil3_in[k] = 17'(18'(9'd256 - ddx[k]) * 18'(9'd256 - ddy[k]));
      end
   end

   // stage 4: table index, rounded to nearest
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         iprod[k]  = PROD_W'(d2_ff[k]) * PROD_W'(SPAN) + PROD_W'(65536);
         idx_in[k] = IDX_W'(iprod[k] >> 17);
      end
   end

   // stage 6: confidence scaling, mode select and floor test
   always_comb begin
      splat_in.ox    = c5_ff.ox;
      splat_in.oy    = c5_ff.oy;
      splat_in.color = c5_ff.color;
      for (int k = 0; k < 4; k++) begin
         gprod[k] = 26'(entry_ff[k]) * 26'(c5_ff.conf) + 26'd128;
         wsel[k]  = weighted_mode ? gprod[k][24:8] : bil5_ff[k];
         splat_in.weight[k] = wsel[k];
         splat_in.keep[k]   = c5_ff.inb[k] && (wsel[k] > ssw_pkg::WEIGHT_FLOOR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      if (advance) begin
         c3_ff    <= c3_in;
         d2_ff    <= d2_in;
         bil3_ff  <= bil3_in;
         c4_ff    <= c3_ff;
         idx_ff   <= idx_in;
         bil4_ff  <= bil3_ff;
         c5_ff    <= c4_ff;
         bil5_ff  <= bil4_ff;
         for (int k = 0; k < 4; k++) begin
            entry_ff[k] <= rom[idx_ff[k]];
         end
         splat_ff <= splat_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_splat = splat_ff;

endmodule

`default_nettype wire

[src/ssw_serializer.sv]
// holds one pixel's kept corners, sends one transaction per cycle while ready
`default_nettype none

module ssw_serializer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire ssw_pkg::splat_type  in_splat,
   output logic                    in_ready,
   ssw_rsp_if.source               rsp
);

   logic               hold_valid_ff;
   logic [3:0]         pend_ff;
   ssw_pkg::splat_type hold_ff;
   logic [3:0]         lowest;
   logic [3:0]         rest;
   logic [1:0]         sel;
   logic               pop;
   logic               last_pop;

   always_comb begin
      lowest = pend_ff & (~pend_ff + 4'd1);
      rest   = pend_ff & ~lowest;
      priority if (pend_ff[0]) sel = 2'd0;
      else if (pend_ff[1])     sel = 2'd1;
      else if (pend_ff[2])     sel = 2'd2;
      else                     sel = 2'd3;
      pop      = hold_valid_ff && rsp.ready;
      last_pop = pop && (rest == 4'b0000);
      in_ready = !hold_valid_ff || last_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (in_ready) begin
         // a pixel with no kept corner is dropped here
         hold_valid_ff <= in_valid && (in_splat.keep != 4'b0000);
      end
      if (in_ready) begin
         pend_ff <= in_splat.keep;
         hold_ff <= in_splat;
      end else if (pop) begin
         pend_ff <= rest;
      end
   end

   assign rsp.valid         = hold_valid_ff;
   assign rsp.out_x         = hold_ff.ox[sel[0]];
   assign rsp.out_y         = hold_ff.oy[sel[1]];
   assign rsp.splat_weight  = hold_ff.weight[sel];
   assign rsp.out_red       = hold_ff.color.red;
   assign rsp.out_green     = hold_ff.color.green;
   assign rsp.out_blue      = hold_ff.color.blue;
   assign rsp.last_of_pixel = (rest == 4'b0000);

   a_hold_has_work: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (pend_ff != 4'b0000))
      else $error("holding register valid with no pending corner");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_of_pixel) |=> rsp.valid)
      else $error("pixel ended without a last transaction");

   a_one_per_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_of_pixel)
         |=> ($countones(pend_ff) == $past($countones(pend_ff)) - 1))
      else $error("pending corner count did not drop by one");

endmodule

`default_nettype wire

[src/subpixel_splat_weights.sv]
// top level: configuration registers, position and weight pipeline, output serializer
`default_nettype none

// Each accepted pixel enters a six-stage pipeline (scaled position, corners and bounds,
// squared distance, exp table index, table read, final weight) and lands in an output
// holding register that sends its kept corners, in row order, one transaction per cycle
// while the result channel is ready. The holding register takes the next pixel in
// the same cycle as its last corner is taken, and the pipeline stalls while its last
// stage holds a pixel that cannot be handed over yet. A pixel with no kept corner
// never uses the result channel. The exp table has EXP_TABLE_ENTRIES constant entries
// built at elaboration; there is no clearing pass.

module subpixel_splat_weights #(
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ssw_req_if.sink                                 req_ch,
   ssw_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [ssw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ssw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [3:0]          scale_ff;
   logic                mode_ff;
   logic [14:0]         width_ff;
   logic [14:0]         height_ff;
   ssw_pkg::cfg_type    cfg;
   ssw_pkg::req_type    req_item;

   logic                advance;
   logic                pos_valid;
   ssw_pkg::geo_type    pos_geo;
   ssw_pkg::color_type  pos_color;
   logic [8:0]          pos_conf;
   logic                wt_valid;
   ssw_pkg::splat_type  wt_splat;
   logic                ser_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= ssw_pkg::SCALE_RESET;
         mode_ff   <= ssw_pkg::MODE_RESET;
         width_ff  <= ssw_pkg::WIDTH_RESET;
         height_ff <= ssw_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ssw_pkg::CSR_SCALE_FACTOR:  scale_ff  <= csr_wdata[3:0];
            ssw_pkg::CSR_WEIGHTED_MODE: mode_ff   <= csr_wdata[0];
            ssw_pkg::CSR_OUT_WIDTH:     width_ff  <= csr_wdata;
            ssw_pkg::CSR_OUT_HEIGHT:    height_ff <= csr_wdata;
         endcase
      end
   end

   // grid is clipped to what the 14-bit coordinates can reach
   always_comb begin
      cfg.scale = scale_ff;
      cfg.wlim  = (width_ff > ssw_pkg::GRID_LIMIT) ? ssw_pkg::GRID_LIMIT : width_ff;
      cfg.hlim  = (height_ff > ssw_pkg::GRID_LIMIT) ? ssw_pkg::GRID_LIMIT : height_ff;
      req_item.pixel_x     = req_ch.pixel_x;
      req_item.pixel_y     = req_ch.pixel_y;
      req_item.color.red   = req_ch.red;
      req_item.color.green = req_ch.green;
      req_item.color.blue  = req_ch.blue;
      req_item.motion_dx   = req_ch.motion_dx;
      req_item.motion_dy   = req_ch.motion_dy;
      req_item.confidence  = req_ch.confidence;
   end

   // whole pipeline moves unless the last stage holds a pixel the serializer cannot take
   assign advance      = !wt_valid || ser_ready;
   assign req_ch.ready = advance;

   ssw_position u_position (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .in_item   (req_item),
      .cfg       (cfg),
      .out_valid (pos_valid),
      .out_geo   (pos_geo),
      .out_color (pos_color),
      .out_conf  (pos_conf)
   );

   ssw_weight #(
      .ENTRIES (EXP_TABLE_ENTRIES)
   ) u_weight (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .weighted_mode (mode_ff),
      .in_valid      (pos_valid),
      .in_geo        (pos_geo),
      .in_color      (pos_color),
      .in_conf       (pos_conf),
      .out_valid     (wt_valid),
      .out_splat     (wt_splat)
   );

   ssw_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (wt_valid),
      .in_splat (wt_splat),
      .in_ready (ser_ready),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench for subpixel_splat_weights: directed and random pixels against a splat predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LUT_SIZE     = 256;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_PIXELS  = 40;

   typedef struct packed {
      logic [13:0] x;
      logic [13:0] y;
      logic [16:0] weight;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last;
   } contribution_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [ssw_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ssw_pkg::CSR_DATA_W-1:0] csr_wdata;

   ssw_req_if req_ch ();
   ssw_rsp_if rsp_ch ();

   subpixel_splat_weights #(
      .EXP_TABLE_ENTRIES(LUT_SIZE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the registers
   logic [3:0]  cfg_scale;
   logic        cfg_weighted;
   logic [14:0] cfg_width;
   logic [14:0] cfg_height;

   longint unsigned  gauss_lut [LUT_SIZE];
   contribution_type pending_splats [$];

   int req_gap_max;
   int rsp_gap_max;
   int cycle_count;
   int mismatches;
   int pixels_sent;
   int splats_checked;
   int configs_applied;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d contributions outstanding", cycle_count,
                  pending_splats.size());
         $display("status: fail");
         $finish;
      end
   end

   // exp(-x) in Q1.16 for table entry idx, via truncated series of exp(-x/8) squared thrice
   function automatic longint unsigned gauss_q16(input int idx);
      longint unsigned x, y, term, s;
      longint          acc;
      int              k;
      x    = ((64'd100 * 64'(idx)) << 30) / (64'd49 * 64'(LUT_SIZE - 1));
      y    = x >> 3;
      term = 64'd1 << 30;
      acc  = 64'sd1 <<< 30;
      for (k = 1; k <= 10; k++) begin
         term = ((term * y) >> 30) / 64'(k);
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      s = (acc > 0) ? 64'(acc) : 64'd0;
      for (k = 0; k < 3; k++) s = (s * s) >> 30;
      return (s * 64'd65536 + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint widen_motion(input logic [13:0] m);
      return longint'({{50{m[13]}}, m});
   endfunction

   // works out the kept corners of one pixel, row by row, and queues them
   function automatic void compute_splats(input ssw_pkg::req_type p);
      longint           posx, posy, x0, y0, fx, fy, ox, oy, ddx, ddy, w, wl, hl, conf, sc;
      longint unsigned  d2, idx;
      int               nx, ny;
      contribution_type c;
      contribution_type found [$];
      wl   = (cfg_width > ssw_pkg::GRID_LIMIT) ? ssw_pkg::GRID_LIMIT : cfg_width;
      hl   = (cfg_height > ssw_pkg::GRID_LIMIT) ? ssw_pkg::GRID_LIMIT : cfg_height;
      sc   = cfg_scale;
      conf = (p.confidence > ssw_pkg::CONF_ONE) ? ssw_pkg::CONF_ONE : p.confidence;
      posx = (longint'(p.pixel_x) * 256 - widen_motion(p.motion_dx)) * sc;
      posy = (longint'(p.pixel_y) * 256 - widen_motion(p.motion_dy)) * sc;
      // arithmetic shift floors toward minus infinity
      x0 = posx >>> 8;
      y0 = posy >>> 8;
      fx = posx & 64'sd255;
      fy = posy & 64'sd255;
      for (ny = 0; ny < 2; ny++) begin
         for (nx = 0; nx < 2; nx++) begin
            ox  = x0 + nx;
            oy  = y0 + ny;
            ddx = (nx == 1) ? 256 - fx : fx;
            ddy = (ny == 1) ? 256 - fy : fy;
            if (ox < 0 || ox >= wl || oy < 0 || oy >= hl) continue;
            if (cfg_weighted) begin
               d2  = ddx * ddx + ddy * ddy;
               idx = (d2 * (LUT_SIZE - 1) + 65536) / 131072;
               w   = (gauss_lut[idx] * conf + 128) >> 8;
            end else begin
               w = (256 - ddx) * (256 - ddy);
            end
            if (w <= ssw_pkg::WEIGHT_FLOOR) continue;
            c.x      = 14'(ox);
            c.y      = 14'(oy);
            c.weight = 17'(w);
            c.red    = p.color.red;
            c.green  = p.color.green;
            c.blue   = p.color.blue;
            c.last   = 1'b0;
            found.insert(found.size(), c);
         end
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) pending_splats.insert(pending_splats.size(), found[i]);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_splat();
      contribution_type want;
      if (pending_splats.size() == 0) begin
         report_mismatch($sformatf("unexpected contribution x=%0d y=%0d w=%0d",
                                   rsp_ch.out_x, rsp_ch.out_y, rsp_ch.splat_weight));
         return;
      end
      want = pending_splats.pop_front();
      if (rsp_ch.out_x !== want.x)
         report_mismatch($sformatf("out_x %0d, predicted %0d", rsp_ch.out_x, want.x));
      if (rsp_ch.out_y !== want.y)
         report_mismatch($sformatf("out_y %0d, predicted %0d", rsp_ch.out_y, want.y));
      if (rsp_ch.splat_weight !== want.weight)
         report_mismatch($sformatf("splat_weight %0d, predicted %0d at (%0d,%0d)",
                                   rsp_ch.splat_weight, want.weight, want.x, want.y));
      if (rsp_ch.out_red !== want.red)
         report_mismatch($sformatf("out_red %0d, predicted %0d", rsp_ch.out_red, want.red));
      if (rsp_ch.out_green !== want.green)
         report_mismatch($sformatf("out_green %0d, predicted %0d", rsp_ch.out_green,
                                   want.green));
      if (rsp_ch.out_blue !== want.blue)
         report_mismatch($sformatf("out_blue %0d, predicted %0d", rsp_ch.out_blue, want.blue));
      if (rsp_ch.last_of_pixel !== want.last)
         report_mismatch($sformatf("last_of_pixel %0b, predicted %0b at (%0d,%0d)",
                                   rsp_ch.last_of_pixel, want.last, want.x, want.y));
      splats_checked++;
   endtask

   // response side: random stall before each transaction, then check it
   initial begin : response_side
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            check_splat();
            stall_left = $urandom_range(0, rsp_gap_max);
            if (stall_left > 0) rsp_ch.ready <= 1'b0;
         end else if (!rsp_ch.ready) begin
            if (stall_left <= 1) rsp_ch.ready <= 1'b1;
            stall_left--;
         end
      end
   end

   function automatic ssw_pkg::req_type make_pixel(input int x, input int y, input int r,
                                                   input int g, input int b, input int dx,
                                                   input int dy, input int conf);
      ssw_pkg::req_type p;
      p.pixel_x     = 12'(x);
      p.pixel_y     = 12'(y);
      p.color.red   = 8'(r);
      p.color.green = 8'(g);
      p.color.blue  = 8'(b);
      p.motion_dx   = 14'(dx);
      p.motion_dy   = 14'(dy);
      p.confidence  = 9'(conf);
      return p;
   endfunction

   // mostly pixels that land on the grid, with small motion and useful confidence
   function automatic ssw_pkg::req_type random_pixel();
      ssw_pkg::req_type p;
      int               wl, hl, lim_x, lim_y;
      wl    = (cfg_width > ssw_pkg::GRID_LIMIT) ? int'(ssw_pkg::GRID_LIMIT) : int'(cfg_width);
      hl    = (cfg_height > ssw_pkg::GRID_LIMIT) ? int'(ssw_pkg::GRID_LIMIT)
                                                 : int'(cfg_height);
      lim_x = (cfg_scale == 0) ? 4095 : wl / int'(cfg_scale) + 1;
      lim_y = (cfg_scale == 0) ? 4095 : hl / int'(cfg_scale) + 1;
      if (lim_x > 4095) lim_x = 4095;
      if (lim_y > 4095) lim_y = 4095;
      p.pixel_x = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, lim_x))
                                             : 12'($urandom_range(0, 4095));
      p.pixel_y = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, lim_y))
                                             : 12'($urandom_range(0, 4095));
      p.color.red   = 8'($urandom_range(0, 255));
      p.color.green = 8'($urandom_range(0, 255));
      p.color.blue  = 8'($urandom_range(0, 255));
      p.motion_dx = ($urandom_range(0, 9) < 7) ? 14'($urandom_range(0, 1023) - 512)
                                               : 14'($urandom());
      p.motion_dy = ($urandom_range(0, 9) < 7) ? 14'($urandom_range(0, 1023) - 512)
                                               : 14'($urandom());
      p.confidence = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(128, 256))
                                                : 9'($urandom_range(0, 511));
      return p;
   endfunction

   task automatic send_pixel(input ssw_pkg::req_type p);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.pixel_x    <= p.pixel_x;
      req_ch.pixel_y    <= p.pixel_y;
      req_ch.red        <= p.color.red;
      req_ch.green      <= p.color.green;
      req_ch.blue       <= p.color.blue;
      req_ch.motion_dx  <= p.motion_dx;
      req_ch.motion_dy  <= p.motion_dy;
      req_ch.confidence <= p.confidence;
      do @(posedge clock); while (!req_ch.ready);
      compute_splats(p);
      pixels_sent++;
   endtask

   // pixels with no kept corner may still be in flight, so let the pipeline empty too
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_splats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input int scale, input int mode, input int width,
                               input int height);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= ssw_pkg::CSR_SCALE_FACTOR;
      csr_wdata <= 15'(scale);
      @(posedge clock);
      csr_index <= ssw_pkg::CSR_WEIGHTED_MODE;
      csr_wdata <= 15'(mode);
      @(posedge clock);
      csr_index <= ssw_pkg::CSR_OUT_WIDTH;
      csr_wdata <= 15'(width);
      @(posedge clock);
      csr_index <= ssw_pkg::CSR_OUT_HEIGHT;
      csr_wdata <= 15'(height);
      @(posedge clock);
      csr_we       <= 1'b0;
      cfg_scale    = 4'(scale);
      cfg_weighted = 1'(mode);
      cfg_width    = 15'(width);
      cfg_height   = 15'(height);
      configs_applied++;
   endtask

   // reset values: gaussian, scale 2, 8192 x 6144
   task automatic test_default_config();
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 256));
      send_pixel(make_pixel(4095, 4095, 255, 255, 255, -8192, -8192, 511));
      send_pixel(make_pixel(4095, 3000, 200, 100, 50, 8191, 8191, 256));
      send_pixel(make_pixel(0, 0, 17, 34, 51, 8191, 8191, 200));
      send_pixel(make_pixel(100, 50, 1, 2, 3, 64, -200, 0));
      send_pixel(make_pixel(1234, 777, 90, 80, 70, 37, 91, 300));
      send_pixel(make_pixel(4095, 3071, 128, 64, 32, 0, 0, 256));
   endtask

   task automatic test_bilinear_corners();
      apply_config(1, 0, 16384, 16384);
      send_pixel(make_pixel(10, 20, 11, 22, 33, 0, 0, 0));
      send_pixel(make_pixel(10, 20, 44, 55, 66, 128, 128, 256));
      send_pixel(make_pixel(0, 0, 77, 88, 99, 128, -64, 100));
      send_pixel(make_pixel(4095, 4095, 255, 0, 255, -8192, -8192, 511));
      send_pixel(make_pixel(7, 9, 0, 255, 0, 1, 255, 256));
   endtask

   // scale 8 with a clamped grid, zero scale and the largest 4-bit scale, 15
   task automatic test_scale_extremes();
      apply_config(8, 1, 32767, 32767);
      send_pixel(make_pixel(2047, 2047, 5, 6, 7, -255, -255, 256));
      send_pixel(make_pixel(4095, 0, 8, 9, 10, 0, 0, 256));
      send_pixel(make_pixel(1000, 500, 200, 201, 202, 33, -77, 256));
      apply_config(0, 1, 100, 100);
      send_pixel(make_pixel(55, 66, 12, 13, 14, -3000, 4000, 180));
      apply_config(15, 0, 16384, 16384);
      send_pixel(make_pixel(500, 700, 21, 22, 23, 3, 5, 256));
      send_pixel(make_pixel(1092, 1092, 31, 32, 33, 17, -17, 256));
   endtask

   // empty grids give nothing, a one-point grid keeps at most a single corner
   task automatic test_grid_bounds();
      apply_config(2, 0, 0, 100);
      send_pixel(make_pixel(3, 3, 1, 1, 1, 0, 0, 256));
      apply_config(2, 1, 50, 0);
      send_pixel(make_pixel(3, 0, 2, 2, 2, 0, 0, 256));
      apply_config(1, 0, 1, 1);
      send_pixel(make_pixel(0, 0, 3, 3, 3, -64, -64, 256));
      send_pixel(make_pixel(0, 0, 4, 4, 4, 64, 64, 256));
      send_pixel(make_pixel(1, 0, 5, 5, 5, 0, 0, 256));
      apply_config(2, 1, 16384, 16384);
      send_pixel(make_pixel(4095, 4095, 6, 6, 6, 0, 0, 256));
   endtask

   // sender waits for every contribution of a pixel before offering the next
   task automatic test_drain_between_pixels();
      int n;
      apply_config(2, 1, 8192, 6144);
      for (n = 0; n < 8; n++) begin
         send_pixel(random_pixel());
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (pending_splats.size() != 0);
      end
   endtask

   task automatic test_random_phases();
      int phase, n;
      int sc, md, wd, ht;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               sc = 2; md = 1; wd = 8192; ht = 6144;
               req_gap_max = 0; rsp_gap_max = 0;
            end
            1: begin
               sc = int'($urandom_range(1, 8)); md = 0;
               wd = int'($urandom_range(64, 16384)); ht = int'($urandom_range(64, 16384));
               req_gap_max = 9; rsp_gap_max = 9;
            end
            2: begin
               sc = 8; md = 1; wd = 16384; ht = 16384;
               req_gap_max = 0; rsp_gap_max = 9;
            end
            3: begin
               sc = 1; md = 0;
               wd = int'($urandom_range(16385, 32767));
               ht = int'($urandom_range(16385, 32767));
               req_gap_max = 9; rsp_gap_max = 0;
            end
            default: begin
               sc = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(9, 15));
               md = int'($urandom_range(0, 1));
               wd = int'($urandom_range(1, 16384)); ht = int'($urandom_range(1, 16384));
               req_gap_max = 9; rsp_gap_max = 9;
            end
         endcase
         apply_config(sc, md, wd, ht);
         for (n = 0; n < PHASE_PIXELS; n++) send_pixel(random_pixel());
      end
   endtask

   initial begin : stimulus
      int i;
      for (i = 0; i < LUT_SIZE; i++) gauss_lut[i] = gauss_q16(i);
      cfg_scale    = ssw_pkg::SCALE_RESET;
      cfg_weighted = ssw_pkg::MODE_RESET;
      cfg_width    = ssw_pkg::WIDTH_RESET;
      cfg_height   = ssw_pkg::HEIGHT_RESET;
      req_gap_max  = 9;
      rsp_gap_max  = 9;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= ssw_pkg::CSR_SCALE_FACTOR;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.pixel_x    <= '0;
      req_ch.pixel_y    <= '0;
      req_ch.red        <= '0;
      req_ch.green      <= '0;
      req_ch.blue       <= '0;
      req_ch.motion_dx  <= '0;
      req_ch.motion_dy  <= '0;
      req_ch.confidence <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_config();
      test_bilinear_corners();
      test_scale_extremes();
      test_grid_bounds();
      test_drain_between_pixels();
      test_random_phases();
      wait_idle();

      $display("%0d pixels over %0d register settings, %0d contributions checked, %0d mismatches",
               pixels_sent, configs_applied, splats_checked, mismatches);
      $display("covered both weight modes, scales 0 to 15, empty and clamped grids, stalls");
      if (mismatches == 0 && pending_splats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
src/ssw_pkg.sv
src/ssw_if.sv
src/ssw_position.sv
src/ssw_weight.sv
src/ssw_serializer.sv
src/subpixel_splat_weights.sv
tb/testbench.sv
